>>> hdl/cbm_pkg.sv
// Package for the cartridge bank mapper: request and result types, decode
// constants and reset values. No dependencies.
`default_nettype none

package cbm_pkg;

    localparam int AddrW     = 16;
    localparam int DataW     = 8;
    localparam int MappedW   = 21;
    localparam int BankW     = 8;
    localparam int CfgIdxW   = 2;
    localparam int PrgSlots  = 3;
    localparam int ChrSlots  = 8;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_PRG   = 2'd2,
        REQ_CHR   = 2'd3
    } req_kind_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CHR_MASK = 2'd1;

    // Write decode keys, taken on address AND DecodeMask
    localparam logic [AddrW-1:0] DecodeMask   = 16'hF007;
    localparam logic [AddrW-1:0] W_PRG0       = 16'h8000;
    localparam logic [AddrW-1:0] W_MIRROR     = 16'h9001;
    localparam logic [AddrW-1:0] W_IRQ_COUNT  = 16'h9005;
    localparam logic [AddrW-1:0] W_IRQ_ARM    = 16'h9006;
    localparam logic [AddrW-1:0] W_PRG1       = 16'hA000;
    localparam logic [AddrW-1:0] W_CHR_BASE   = 16'hB000;
    localparam logic [AddrW-1:0] W_PRG2       = 16'hC000;

    localparam logic [BankW-1:0] PrgFixedBank = 8'hFF;
    localparam logic [BankW-1:0] PrgReset0    = 8'h00;
    localparam logic [BankW-1:0] PrgReset1    = 8'h01;
    localparam logic [BankW-1:0] PrgReset2    = 8'hFE;
    localparam logic [BankW-1:0] MaskReset    = 8'hFF;

    typedef struct packed {
        req_kind_t              kind;
        logic [AddrW-1:0]       addr;
        logic [DataW-1:0]       data;
    } req_t;

    typedef struct packed {
        logic [MappedW-1:0]     mapped_address;
        logic                   address_hit;
        logic                   irq_request;
        logic                   mirror_vertical;
    } res_t;

endpackage

`default_nettype wire

>>> hdl/cbm_core.sv
// Mapper state and request decode: bank registers, mirroring, scanline
// interrupt counter and address translation. Uses cbm_pkg.
`default_nettype none

module cbm_core
    import cbm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               req_fire,
    input  wire req_t               req,
    input  wire logic [BankW-1:0]   prg_mask,
    input  wire logic [BankW-1:0]   chr_mask,
    output res_t                    res
);

    logic [BankW-1:0] prg_bank_reg [PrgSlots];
    logic [BankW-1:0] prg_bank_next [PrgSlots];
    logic [BankW-1:0] chr_bank_reg [ChrSlots];
    logic [BankW-1:0] chr_bank_next [ChrSlots];
    logic             mirror_reg, mirror_next;
    logic [7:0]       irq_count_reg, irq_count_next;
    logic             irq_armed_reg, irq_armed_next;

    logic [AddrW-1:0] key;
    logic [1:0]       prg_slot;
    logic [BankW-1:0] prg_bank;
    logic [BankW-1:0] chr_bank;

    assign key      = req.addr & DecodeMask;
    assign prg_slot = req.addr[14:13];

    // Decode the request: state update and result
    always_comb begin
        prg_bank_next  = prg_bank_reg;
        chr_bank_next  = chr_bank_reg;
        mirror_next    = mirror_reg;
        irq_count_next = irq_count_reg;
        irq_armed_next = irq_armed_reg;
        res            = '0;
        prg_bank       = (prg_slot == 2'd3) ? PrgFixedBank : prg_bank_reg[prg_slot];
        prg_bank       = prg_bank & prg_mask;
        chr_bank       = chr_bank_reg[req.addr[12:10]] & chr_mask;

        case (req.kind)
            REQ_WRITE: begin
                if (req.addr[15]) begin
                    if (key == W_PRG0) prg_bank_next[0] = req.data;
                    if (key == W_PRG1) prg_bank_next[1] = req.data;
                    if (key == W_PRG2) prg_bank_next[2] = req.data;
                    if (key == W_MIRROR) mirror_next = req.data[7];
                    if (key == W_IRQ_COUNT) irq_count_next = {req.data[6:0], 1'b0};
                    if (key == W_IRQ_ARM) irq_armed_next = (irq_count_reg != 8'd0);
                    if ((key & ~16'h0007) == W_CHR_BASE) begin
                        chr_bank_next[req.addr[2:0]] = req.data;
                    end
                end
            end
            REQ_TICK: begin
                if (irq_armed_reg) begin
                    if (irq_count_reg == 8'd0) begin
                        irq_armed_next  = 1'b0;
                        res.irq_request = 1'b1;
                    end else begin
                        irq_count_next = irq_count_reg - 8'd1;
                    end
                end
            end
            REQ_PRG: begin
                if (req.addr[15]) begin
                    res.address_hit    = 1'b1;
                    res.mapped_address = {prg_bank, req.addr[12:0]};
                end
            end
            REQ_CHR: begin
                if (req.addr[15:13] == 3'd0) begin
                    res.address_hit    = 1'b1;
                    res.mapped_address = MappedW'({chr_bank, req.addr[9:0]});
                end
            end
            default: begin
            end
        endcase

        res.mirror_vertical = mirror_next;
    end

    // Commit state when the request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_bank_reg[0] <= PrgReset0;
            prg_bank_reg[1] <= PrgReset1;
            prg_bank_reg[2] <= PrgReset2;
            for (int i = 0; i < ChrSlots; i++) begin
                chr_bank_reg[i] <= BankW'(i);
            end
            mirror_reg    <= 1'b0;
            irq_count_reg <= 8'd0;
            irq_armed_reg <= 1'b0;
        end else if (req_fire) begin
            prg_bank_reg  <= prg_bank_next;
            chr_bank_reg  <= chr_bank_next;
            mirror_reg    <= mirror_next;
            irq_count_reg <= irq_count_next;
            irq_armed_reg <= irq_armed_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cartridge_bank_mapper_scanline_irq_core.sv
// Result path: the accepted request is held in the input register, then moved to
// the result register once that is free. Throughput: one request per cycle while
// the result is not stalled; a request is still taken while one result waits, set
// by the two-entry register path.
// Reset: synchronous, active low; clears both valid flags, bank registers to
// 0,1,0xFE and entry i = i, mirroring, counter and arming to 0, masks to 0xFF.
// Top level of the cartridge bank mapper; uses cbm_pkg and cbm_core.
`default_nettype none

module cartridge_bank_mapper_scanline_irq_core
    import cbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_req_type,
    input  wire logic [AddrW-1:0]     s_bus_address,
    input  wire logic [DataW-1:0]     s_write_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [MappedW-1:0]        m_mapped_address,
    output logic                      m_address_hit,
    output logic                      m_irq_request,
    output logic                      m_mirror_vertical,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [BankW-1:0]     cfg_data
);

    logic             in_valid_reg;
    req_t             in_req_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    res_t             core_res;
    logic             advance;
    logic [BankW-1:0] prg_mask_reg;
    logic [BankW-1:0] chr_mask_reg;

    // Move the held request on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.kind <= req_kind_t'(s_req_type);
            in_req_reg.addr <= s_bus_address;
            in_req_reg.data <= s_write_data;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_mask_reg <= MaskReset;
            chr_mask_reg <= MaskReset;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_PRG_MASK) prg_mask_reg <= cfg_data;
            if (cfg_index == CFG_CHR_MASK) chr_mask_reg <= cfg_data;
        end
    end

    cbm_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_fire (advance),
        .req      (in_req_reg),
        .prg_mask (prg_mask_reg),
        .chr_mask (chr_mask_reg),
        .res      (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_mapped_address  = out_res_reg.mapped_address;
    assign m_address_hit     = out_res_reg.address_hit;
    assign m_irq_request     = out_res_reg.irq_request;
    assign m_mirror_vertical = out_res_reg.mirror_vertical;

endmodule

`default_nettype wire

>>> hdl/cbm_checker.sv
// Port-level checks for the cartridge bank mapper top level, with the bind
// that attaches them. Uses cbm_pkg.
`default_nettype none

module cbm_checker
    import cbm_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [MappedW-1:0] m_mapped_address,
    input wire logic               m_address_hit,
    input wire logic               m_irq_request
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mapped_address)
            && $stable(m_address_hit) && $stable(m_irq_request))
        else $error("stalled result changed");

    // No valid result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A miss carries a zero address
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_address_hit |-> m_mapped_address == '0)
        else $error("nonzero address on miss");

    // An interrupt never comes with a translate hit
    a_irq_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_request |-> !m_address_hit)
        else $error("interrupt with address hit");

    // An empty pipeline always takes a request
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!s_valid) && $past(aresetn) |-> s_ready)
        else $error("request refused while empty");

endmodule

bind cartridge_bank_mapper_scanline_irq_core cbm_checker u_cbm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mapped_address (m_mapped_address),
    .m_address_hit    (m_address_hit),
    .m_irq_request    (m_irq_request)
);

`default_nettype wire
